[hdl/atlas_rect_allocator_assert.svh]
// ---------------------------------------------------------------------------
// Atlas rectangle allocator assertion macros
// Property forms used by the allocator controller.
// ---------------------------------------------------------------------------
`ifndef ATLAS_RECT_ALLOCATOR_ASSERT_SVH
`define ATLAS_RECT_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ATL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ATL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/atl_pkg.sv]
// ---------------------------------------------------------------------------
// Atlas allocator package
// Types, constants and control structs shared by the allocator modules.
// ---------------------------------------------------------------------------
`default_nettype none
package atl_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int ENT_W       = 58;
  localparam int DIV_W       = 16;
  localparam int DIV_CNT_W   = $clog2(DIV_W + 1);

  localparam logic [13:0] COORD_MAX = 14'h3fff;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_OVERLAP = 2'd1;
  localparam logic [1:0] STATUS_NO_ROOM = 2'd2;
  localparam logic [1:0] STATUS_FULL    = 2'd3;

  localparam logic [1:0] REG_CELL_W   = 2'd0;
  localparam logic [1:0] REG_CELL_H   = 2'd1;
  localparam logic [1:0] REG_MAX_SIDE = 2'd2;
  localparam logic [1:0] REG_INIT     = 2'd3;

  localparam logic CMD_PLACE = 1'b0;
  localparam logic CMD_CLAIM = 1'b1;

  localparam logic [14:0] CELL_RST     = 15'd1;
  localparam logic [14:0] MAX_SIDE_RST = 15'd4096;
  localparam logic [14:0] INIT_RST     = 15'd256;

  typedef struct packed {
    logic        command;
    logic [14:0] rect_width;
    logic [14:0] rect_height;
    logic [13:0] claim_x;
    logic [13:0] claim_y;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  entry_index;
    logic [13:0] placed_x;
    logic [13:0] placed_y;
    logic [14:0] atlas_side;
  } out_word_t;

  typedef struct packed {
    logic       load;
    logic       place_init;
    logic       bounds;
    logic       row_init;
    logic       col_init;
    logic       x_zero;
    logic       step;
    logic       row_acc;
    logic       div_x;
    logic       div_y;
    logic       side_dbl;
    logic       store;
    logic       finish;
    logic [1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic claim;
    logic side_zero;
    logic too_big;
    logic scan_end;
    logic hit;
    logic x_ok;
    logic y_ok;
    logic any;
    logic dbl_over;
    logic div_done;
  } dp_sts_t;

endpackage
`default_nettype wire

[hdl/atl_ram.sv]
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module atl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hdl/atl_rem.sv]
// ---------------------------------------------------------------------------
// Atlas allocator round-up unit
// Restoring remainder, one bit per cycle, rounding a value up to a multiple of a step.
// ---------------------------------------------------------------------------
`default_nettype none
module atl_rem (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [atl_pkg::DIV_W-1:0] value,
  input  wire logic [14:0]              step,
  output logic                          done,
  output logic      [atl_pkg::DIV_W:0]  rounded
);

  logic                            run_r, run_nxt;
  logic [atl_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [atl_pkg::DIV_W-1:0]       val_r, val_nxt;
  logic [atl_pkg::DIV_W-1:0]       sh_r, sh_nxt;
  logic [14:0]                     step_r, step_nxt;
  logic [14:0]                     rem_r, rem_nxt;
  logic [15:0]                     trial;

  assign done  = run_r && (cnt_r == atl_pkg::DIV_CNT_W'(atl_pkg::DIV_W));
  assign trial = {rem_r, sh_r[atl_pkg::DIV_W-1]};

  always_comb begin
    run_nxt  = run_r;
    cnt_nxt  = cnt_r;
    val_nxt  = val_r;
    sh_nxt   = sh_r;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    if (start) begin
      run_nxt  = 1'b1;
      cnt_nxt  = '0;
      val_nxt  = value;
      sh_nxt   = value;
      step_nxt = step;
      rem_nxt  = '0;
    end else if (done) begin
      run_nxt = 1'b0;
    end else if (run_r) begin
      cnt_nxt = cnt_r + 1'b1;
      sh_nxt  = {sh_r[atl_pkg::DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, step_r}) begin
        rem_nxt = 15'(trial - {1'b0, step_r});
      end else begin
        rem_nxt = trial[14:0];
      end
    end
  end

  always_comb begin
    if (rem_r == '0) begin
      rounded = {1'b0, val_r};
    end else begin
      rounded = {1'b0, val_r} - {2'b0, rem_r} + {2'b0, step_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    val_r  <= val_nxt;
    sh_r   <= sh_nxt;
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
  end

endmodule
`default_nettype wire

[hdl/atl_dp.sv]
// ---------------------------------------------------------------------------
// Atlas allocator datapath
// Registers, rectangle table, overlap tests, result and configuration port.
// ---------------------------------------------------------------------------
`default_nettype none
module atl_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire atl_pkg::dp_cmd_t    cmd,
  output atl_pkg::dp_sts_t         sts,
  input  wire atl_pkg::in_word_t   in_data,
  output logic                     out_valid,
  output atl_pkg::out_word_t       out_data,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata
);

  atl_pkg::in_word_t          in_r, in_nxt;
  atl_pkg::out_word_t         out_r, out_nxt;
  logic                       out_valid_r;
  logic [14:0]                cw_r, ch_r, max_r, init_r, cur_r;
  logic [14:0]                side_r, side_nxt;
  logic [13:0]                xmax_r, xmax_nxt, ymax_r, ymax_nxt;
  logic [16:0]                x_r, x_nxt, y_r, y_nxt;
  logic [atl_pkg::CNT_W-1:0]  idx_r, idx_nxt, cnt_r;
  logic                       any_r, any_nxt;
  logic [15:0]                yend_r, yend_nxt;
  logic                       div_to_x_r;
  logic [atl_pkg::ENT_W-1:0]  rd_data;
  logic [13:0]                ex, ey;
  logic [14:0]                ew, eh, cw_eff, ch_eff, dx, dy;
  logic [15:0]                ex_end, ey_end;
  logic [17:0]                x_far, y_far;
  logic                       vovl, cfg_we, div_start, div_done;
  logic [16:0]                div_res;
  logic [15:0]                div_val;
  logic [14:0]                div_step, wval;

  assign ex     = rd_data[57:44];
  assign ey     = rd_data[43:30];
  assign ew     = rd_data[29:15];
  assign eh     = rd_data[14:0];
  assign ex_end = {2'b0, ex} + {1'b0, ew};
  assign ey_end = {2'b0, ey} + {1'b0, eh};
  assign x_far  = {1'b0, x_r} + {3'b0, in_r.rect_width};
  assign y_far  = {1'b0, y_r} + {3'b0, in_r.rect_height};
  assign vovl   = (y_r < {1'b0, ey_end}) && ({4'b0, ey} < y_far);
  assign cw_eff = (cw_r == '0) ? 15'd1 : cw_r;
  assign ch_eff = (ch_r == '0) ? 15'd1 : ch_r;
  assign dx     = side_r - in_r.rect_width;
  assign dy     = side_r - in_r.rect_height;

  assign sts.full      = cnt_r >= atl_pkg::CNT_W'(atl_pkg::MAX_ENTRIES);
  assign sts.claim     = in_r.command == atl_pkg::CMD_CLAIM;
  assign sts.side_zero = cur_r == '0;
  assign sts.too_big   = (in_r.rect_width > side_r) || (in_r.rect_height > side_r);
  assign sts.scan_end  = idx_r == cnt_r;
  assign sts.hit       = vovl && (x_r < {1'b0, ex_end}) && ({4'b0, ex} < x_far);
  assign sts.x_ok      = x_r <= {3'b0, xmax_r};
  assign sts.y_ok      = y_r <= {3'b0, ymax_r};
  assign sts.any       = any_r;
  assign sts.dbl_over  = {side_r, 1'b0} > {1'b0, max_r};
  assign sts.div_done  = div_done;

  assign div_start = cmd.div_x || cmd.div_y;
  assign div_val   = cmd.div_x ? ex_end : yend_r;
  assign div_step  = cmd.div_x ? cw_eff : ch_eff;

  atl_rem u_rem (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .value   (div_val),
    .step    (div_step),
    .done    (div_done),
    .rounded (div_res)
  );

  atl_ram #(
    .WIDTH (atl_pkg::ENT_W),
    .DEPTH (atl_pkg::MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (cnt_r[atl_pkg::IDX_W-1:0]),
    .wdata ({x_r[13:0], y_r[13:0], in_r.rect_width, in_r.rect_height}),
    .raddr (idx_r[atl_pkg::IDX_W-1:0]),
    .rdata (rd_data)
  );

  always_comb begin
    in_nxt   = in_r;
    side_nxt = side_r;
    xmax_nxt = xmax_r;
    ymax_nxt = ymax_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    idx_nxt  = idx_r;
    any_nxt  = any_r;
    yend_nxt = yend_r;
    if (cmd.load) begin
      in_nxt = in_data;
      x_nxt  = {3'b0, in_data.claim_x};
      y_nxt  = {3'b0, in_data.claim_y};
    end
    if (cmd.place_init) begin
      side_nxt = cur_r;
    end
    if (cmd.side_dbl) begin
      side_nxt = {side_r[13:0], 1'b0};
    end
    if (cmd.bounds) begin
      xmax_nxt = (dx > {1'b0, atl_pkg::COORD_MAX}) ? atl_pkg::COORD_MAX : dx[13:0];
      ymax_nxt = (dy > {1'b0, atl_pkg::COORD_MAX}) ? atl_pkg::COORD_MAX : dy[13:0];
      y_nxt    = '0;
    end
    if (cmd.row_init) begin
      idx_nxt  = '0;
      any_nxt  = 1'b0;
      yend_nxt = '1;
    end
    if (cmd.col_init) begin
      idx_nxt = '0;
    end
    if (cmd.x_zero) begin
      x_nxt = '0;
    end
    if (cmd.step) begin
      idx_nxt = idx_r + 1'b1;
    end
    if (cmd.row_acc && vovl) begin
      any_nxt = 1'b1;
      if (ey_end < yend_r) begin
        yend_nxt = ey_end;
      end
    end
    if (div_done) begin
      if (div_to_x_r) begin
        x_nxt = div_res;
      end else begin
        y_nxt = div_res;
      end
    end
  end

  always_comb begin
    out_nxt = out_r;
    if (cmd.finish) begin
      out_nxt.status      = cmd.status;
      out_nxt.entry_index = '0;
      out_nxt.placed_x    = '0;
      out_nxt.placed_y    = '0;
      out_nxt.atlas_side  = cur_r;
      if (cmd.store) begin
        out_nxt.entry_index = cnt_r[5:0];
        out_nxt.placed_x    = x_r[13:0];
        out_nxt.placed_y    = y_r[13:0];
        if (!sts.claim) begin
          out_nxt.atlas_side = side_r;
        end
      end
    end
  end

  assign cfg_we = psel && penable && pwrite;
  assign wval   = pwdata[14:0];

  always_comb begin
    unique case (paddr[3:2])
      atl_pkg::REG_CELL_W:   prdata = {17'b0, cw_r};
      atl_pkg::REG_CELL_H:   prdata = {17'b0, ch_r};
      atl_pkg::REG_MAX_SIDE: prdata = {17'b0, max_r};
      atl_pkg::REG_INIT:     prdata = {17'b0, init_r};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r        <= atl_pkg::CELL_RST;
      ch_r        <= atl_pkg::CELL_RST;
      max_r       <= atl_pkg::MAX_SIDE_RST;
      init_r      <= atl_pkg::INIT_RST;
      cur_r       <= atl_pkg::INIT_RST;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (cmd.store) begin
        cnt_r <= cnt_r + 1'b1;
        if (!sts.claim) begin
          cur_r <= side_r;
        end
      end
      if (cfg_we) begin
        unique case (paddr[3:2])
          atl_pkg::REG_CELL_W:   cw_r  <= wval;
          atl_pkg::REG_CELL_H:   ch_r  <= wval;
          atl_pkg::REG_MAX_SIDE: max_r <= wval;
          atl_pkg::REG_INIT: begin
            init_r <= wval;
            if (cnt_r == '0) begin
              cur_r <= wval;
            end
          end
          default: init_r <= init_r;
        endcase
      end
    end
    if (div_start) begin
      div_to_x_r <= cmd.div_x;
    end
    in_r   <= in_nxt;
    out_r  <= out_nxt;
    side_r <= side_nxt;
    xmax_r <= xmax_nxt;
    ymax_r <= ymax_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    idx_r  <= idx_nxt;
    any_r  <= any_nxt;
    yend_r <= yend_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

[hdl/atl_ctrl.sv]
// ---------------------------------------------------------------------------
// Atlas allocator controller
// Sequences table scans, row and column stepping and atlas growth.
// ---------------------------------------------------------------------------
`default_nettype none
`include "atlas_rect_allocator_assert.svh"
module atl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire atl_pkg::dp_sts_t  sts,
  output atl_pkg::dp_cmd_t       cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_SIDE  = 4'd2;
  localparam logic [3:0] S_ROWI  = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_CMP   = 4'd5;
  localparam logic [3:0] S_COLS  = 4'd6;
  localparam logic [3:0] S_DIVX  = 4'd7;
  localparam logic [3:0] S_DIVY  = 4'd8;
  localparam logic [3:0] S_YCHK  = 4'd9;
  localparam logic [3:0] S_GROW  = 4'd10;

  localparam logic [1:0] M_CLAIM = 2'd0;
  localparam logic [1:0] M_ROW   = 2'd1;
  localparam logic [1:0] M_COL   = 2'd2;

  logic [3:0] state_r, state_nxt;
  logic [1:0] mode_r, mode_nxt;

  assign busy = state_r != S_IDLE;

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (sts.full) begin
          cmd.finish = 1'b1;
          cmd.status = atl_pkg::STATUS_FULL;
          state_nxt  = S_IDLE;
        end else if (sts.claim) begin
          cmd.col_init = 1'b1;
          mode_nxt     = M_CLAIM;
          state_nxt    = S_RD;
        end else if (sts.side_zero) begin
          cmd.finish = 1'b1;
          cmd.status = atl_pkg::STATUS_NO_ROOM;
          state_nxt  = S_IDLE;
        end else begin
          cmd.place_init = 1'b1;
          state_nxt      = S_SIDE;
        end
      end
      S_SIDE: begin
        if (sts.too_big) begin
          state_nxt = S_GROW;
        end else begin
          cmd.bounds = 1'b1;
          state_nxt  = S_ROWI;
        end
      end
      S_ROWI: begin
        cmd.row_init = 1'b1;
        mode_nxt     = M_ROW;
        state_nxt    = S_RD;
      end
      S_RD: begin
        if (sts.scan_end) begin
          if (mode_r == M_ROW) begin
            cmd.x_zero = 1'b1;
            state_nxt  = S_COLS;
          end else begin
            cmd.store  = 1'b1;
            cmd.finish = 1'b1;
            cmd.status = atl_pkg::STATUS_OK;
            state_nxt  = S_IDLE;
          end
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        priority if (mode_r == M_ROW) begin
          cmd.row_acc = 1'b1;
          cmd.step    = 1'b1;
          state_nxt   = S_RD;
        end else if (sts.hit && mode_r == M_CLAIM) begin
          cmd.finish = 1'b1;
          cmd.status = atl_pkg::STATUS_OVERLAP;
          state_nxt  = S_IDLE;
        end else if (sts.hit) begin
          cmd.div_x = 1'b1;
          state_nxt = S_DIVX;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_COLS: begin
        priority if (sts.x_ok) begin
          cmd.col_init = 1'b1;
          mode_nxt     = M_COL;
          state_nxt    = S_RD;
        end else if (!sts.any) begin
          state_nxt = S_GROW;
        end else begin
          cmd.div_y = 1'b1;
          state_nxt = S_DIVY;
        end
      end
      S_DIVX: begin
        if (sts.div_done) begin
          state_nxt = S_COLS;
        end
      end
      S_DIVY: begin
        if (sts.div_done) begin
          state_nxt = S_YCHK;
        end
      end
      S_YCHK: begin
        state_nxt = sts.y_ok ? S_ROWI : S_GROW;
      end
      S_GROW: begin
        if (sts.dbl_over) begin
          cmd.finish = 1'b1;
          cmd.status = atl_pkg::STATUS_NO_ROOM;
          state_nxt  = S_IDLE;
        end else begin
          cmd.side_dbl = 1'b1;
          state_nxt    = S_SIDE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= M_CLAIM;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
    end
  end

  `ATL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "Accepted word did not raise busy.")
  `ATL_ASSERT_SAME(a_store_room, cmd.store, !sts.full, "Store issued with a full table.")
  `ATL_ASSERT_NEXT(a_finish_idle, cmd.finish, !busy, "Controller busy after a result.")

endmodule
`default_nettype wire

[hdl/atlas_rect_allocator.sv]
// ---------------------------------------------------------------------------
// Atlas rectangle allocator
// First-fit rectangle placement in a square texture atlas that can grow.
// ---------------------------------------------------------------------------
// A word is taken when start is high and busy is low, and exactly one result
// word follows, shown for a single cycle with out_valid; the receiver cannot
// stall it, so it must take every result when it appears. Every pass over the
// stored rectangles reads the table through its one read port, one entry at a
// time with a read state and a compare state for each, so a claim takes at most
// one pass. A place scans the whole table for each row tried, then scans each
// column candidate until it fails at an entry, jumps to the next grid column
// or the next grid row through the round-up unit, and does this again for each
// doubling of the atlas side.
// ---------------------------------------------------------------------------
`default_nettype none
module atlas_rect_allocator (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire atl_pkg::in_word_t   in_data,
  output logic                     out_valid,
  output atl_pkg::out_word_t       out_data,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready
);

  atl_pkg::dp_cmd_t cmd;
  atl_pkg::dp_sts_t sts;

  assign pready = 1'b1;

  atl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  atl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
  );

endmodule
`default_nettype wire
